[rtl/core/sync_crc16_frame_receiver_macros.svh]
// Assertion helpers for the frame receiver; clk and rst are taken from the enclosing module.
`ifndef SYNC_CRC16_FRAME_RECEIVER_MACROS_SVH
`define SYNC_CRC16_FRAME_RECEIVER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SC16_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sc16 check failed");
`define SC16_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sc16 check failed");
`else
`define SC16_ASSERT_IMP(lbl, ante, cons)
`define SC16_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/sc16_pkg.sv]
package sc16_pkg;

  localparam logic [7:0]  SYNC_A        = 8'h41;
  localparam logic [7:0]  SYNC_B        = 8'h42;
  localparam logic [7:0]  SYNC_C        = 8'h43;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam int          PAYLOAD_DEPTH = 8;
  localparam int          PIDX_W        = $clog2(PAYLOAD_DEPTH);
  localparam int          OUT_DATA_W    = 80;

  typedef enum logic [3:0] {
    ST_HUNT   = 4'b0001,
    ST_BODY   = 4'b0010,
    ST_CRC_LO = 4'b0100,
    ST_CRC_HI = 4'b1000
  } rx_state_t;

  typedef struct packed {
    logic        frame_ok;
    logic [15:0] good_frame_count;
    logic [PAYLOAD_DEPTH-1:0][7:0] payload;   // entry 0 is the command byte
  } frame_result_t;

  typedef struct packed {
    logic        hunting;
    logic [1:0]  sync_matched;
    logic [15:0] good_count;
  } rx_status_t;

  // MSB-first CRC-16, polynomial 0x1021, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/core/sync_crc16_frame_receiver.sv]
// Channel  Dir  Word                                                    Accept
// s        in   tdata[7:0] rx_byte                                      s_tvalid & s_tready
// m        out  tdata: command, data_0..data_6, good_frame_count;       m_tvalid & m_tready
//               tuser: frame_ok
// One received byte is taken per cycle while s_tready is high; a frame result leaves
// from the output register in the cycle after its last CRC byte is taken.
// s_tready drops only while a finished result waits in the output register and
// m_tready is low.
// Synchronous reset returns to hunting with a zero good-frame count.
`include "sync_crc16_frame_receiver_macros.svh"

module sync_crc16_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] command_byte, [15:8] data_0 .. [63:56] data_6, [79:64] good_frame_count
  output logic [sc16_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [0:0]  m_tuser    // [0] frame_ok
);
  import sc16_pkg::*;

  logic          fire;
  logic          res_valid;
  frame_result_t res;
  rx_status_t    status;

  assign fire = s_tvalid && s_tready;

  sc16_frame_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  sc16_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .in_ready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  `SC16_ASSERT_NXT(a_result_shown, res_valid, m_tvalid)
  `SC16_ASSERT_IMP(a_count_matches, m_tvalid, m_tdata[79:64] == status.good_count)
  `SC16_ASSERT_IMP(a_sync_clear_in_frame, !status.hunting, status.sync_matched == 2'd0)

endmodule

[rtl/core/sc16_frame_ctl.sv]
module sc16_frame_ctl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             rx_byte,
  output logic                   res_valid,
  output sc16_pkg::frame_result_t res,
  output sc16_pkg::rx_status_t   status
);
  import sc16_pkg::*;

  localparam logic [PIDX_W-1:0] BODY_LAST = PIDX_W'(PAYLOAD_DEPTH - 1);

  rx_state_t              state;
  logic [1:0]             sync_matched;
  logic [PIDX_W-1:0]      idx;
  logic [15:0]            running_crc;
  logic [15:0]            good_count;
  logic [7:0]             crc_low_store;
  logic [PAYLOAD_DEPTH-1:0][7:0] payload_store;

  logic        frame_ok;
  logic [15:0] good_count_next;

  assign frame_ok        = ({rx_byte, crc_low_store} == running_crc);
  assign good_count_next = frame_ok ? good_count + 16'd1 : good_count;
  assign res_valid       = fire && (state == ST_CRC_HI);

  assign res.frame_ok         = frame_ok;
  assign res.good_frame_count = good_count_next;
  assign res.payload          = payload_store;

  assign status.hunting      = (state == ST_HUNT);
  assign status.sync_matched = sync_matched;
  assign status.good_count   = good_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_HUNT;
      sync_matched <= 2'd0;
      idx          <= '0;
      running_crc  <= 16'd0;
      good_count   <= 16'd0;
    end else if (fire) begin
      case (state)
        ST_HUNT: begin
          if (sync_matched == 2'd2 && rx_byte == SYNC_C) begin
            state        <= ST_BODY;
            sync_matched <= 2'd0;
            idx          <= '0;
            running_crc  <= 16'd0;
          end else if (sync_matched == 2'd1 && rx_byte == SYNC_B) begin
            sync_matched <= 2'd2;
          end else if (rx_byte == SYNC_A) begin
            // a broken sync may still start a new one
            sync_matched <= 2'd1;
          end else begin
            sync_matched <= 2'd0;
          end
        end
        ST_BODY: begin
          running_crc <= crc16_byte(running_crc, rx_byte);
          idx         <= idx + 1'b1;
          if (idx == BODY_LAST) begin
            state <= ST_CRC_LO;
          end
        end
        ST_CRC_LO: begin
          state <= ST_CRC_HI;
        end
        ST_CRC_HI: begin
          good_count   <= good_count_next;
          state        <= ST_HUNT;
          sync_matched <= 2'd0;
        end
        default: begin
          state        <= ST_HUNT;
          sync_matched <= 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire && state == ST_BODY) begin
      payload_store[idx] <= rx_byte;
    end
    if (fire && state == ST_CRC_LO) begin
      crc_low_store <= rx_byte;
    end
  end

endmodule

[rtl/core/sc16_out_reg.sv]
module sc16_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    res_valid,
  input  sc16_pkg::frame_result_t res,
  output logic                    in_ready,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [sc16_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [0:0]              m_tuser
);
  import sc16_pkg::*;

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // hold the word until it is taken
  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {res.good_frame_count, res.payload};
      m_tuser <= res.frame_ok;
    end
  end

endmodule
